### rtl/page_run_allocator_unit_macros.svh
// Assertion helpers for the page run allocator.
`ifndef PAGE_RUN_ALLOCATOR_UNIT_MACROS_SVH
`define PAGE_RUN_ALLOCATOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define PRAU_ASSERT(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
	else $error("prau assertion failed");
`define PRAU_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
	else $error("prau assertion failed");
`else
`define PRAU_ASSERT(lbl, clk, rst_n, cond)
`define PRAU_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif
`endif

### rtl/prau_pkg.sv
`default_nettype none
package prau_pkg;
	localparam int NUM_PAGES     = 1024;
	localparam int MAP_WORD_BITS = 32;
	localparam int MAP_WORDS     = (NUM_PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
	localparam int PG_W          = 10;
	localparam int CNT_W         = 11;
	localparam int BIT_W         = $clog2(MAP_WORD_BITS);
	localparam int WA_W          = $clog2(MAP_WORDS);

	localparam logic CFG_RESERVED = 1'b0;
	localparam logic CFG_TOTAL    = 1'b1;

	typedef enum logic [1:0] {OP_ALLOC, OP_FREE, OP_LOOKUP, OP_NEXT} op_t;
	typedef enum logic [1:0] {ST_OK, ST_NOSPACE, ST_BAD, ST_NOTFOUND} status_t;

	typedef enum logic [3:0] {
		S_IDLE, S_A_RD, S_A_CHK, S_M_RD, S_M_WR, S_F_RD, S_F_CHK, S_F_MRD,
		S_F_MWR, S_L_RD, S_L_CHK, S_L_LEN, S_N_RD, S_N_CHK, S_DONE
	} state_t;
endpackage
`default_nettype wire

### rtl/prau_ram.sv
`default_nettype none
module prau_ram #(
	parameter int W  = 8,
	parameter int D  = 16,
	parameter int AW = $clog2(D)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [W-1:0]  wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [W-1:0]  rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

### rtl/page_run_allocator_unit.sv
// channel | dir | handshake             | payload
// in      | in  | in_valid / in_stall   | opcode, page_count, page_index
// out     | out | out_valid / out_stall | status, head_page, run_pages
// cfg     | in  | cfg_valid / cfg_ready | cfg_index, cfg_data
// One item at a time; each page visited is a memory read, then a use of the data.
// Alloc scans then claims each page of the run; free checks the head, then releases
// each page; lookup checks the page, then reads the length; next scans; DONE posts.
// Reset clears the free bitmap through per-word valid bits; no clearing pass.
// A stalled result sits in the output register while the next beat is accepted.
`default_nettype none
`include "page_run_allocator_unit_macros.svh"
module page_run_allocator_unit
	import prau_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [1:0]       opcode,
	input  wire logic [CNT_W-1:0] page_count,
	input  wire logic [PG_W-1:0]  page_index,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic [1:0]            status,
	output logic [PG_W-1:0]       head_page,
	output logic [CNT_W-1:0]      run_pages,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic             cfg_index,
	input  wire logic [CNT_W-1:0] cfg_data
);
	state_t state_q, state_d;
	logic [CNT_W-1:0] reserved_q, total_q, bound_q, p_q, cnt_q, want_q, len_q;
	logic [PG_W-1:0] base_q, idx_q, res_head_q;
	logic [CNT_W-1:0] res_len_q;
	status_t res_st_q;
	logic out_valid_q;
	logic [MAP_WORDS-1:0] fm_vld_q;
	logic fm_hit_q;

	logic fm_we, oh_we, rl_we;
	logic [WA_W-1:0] fm_addr;
	logic [MAP_WORD_BITS-1:0] fm_rdata, fm_word, fm_wdata;
	logic [PG_W-1:0] oh_rdata, rl_raddr;
	logic [CNT_W-1:0] rl_rdata;
	logic pbit, out_free;
	logic [CNT_W:0] p_inc, run_end;

	assign cfg_ready = 1'b1;
	assign fm_addr = p_q[PG_W-1:BIT_W];
	assign fm_word = fm_hit_q ? fm_rdata : '1;
	assign pbit = fm_word[p_q[BIT_W-1:0]];
	assign out_free = !out_valid_q || !out_stall;
	assign p_inc = {1'b0, p_q} + 1'b1;
	assign run_end = {2'b00, base_q} + {1'b0, want_q};

	prau_ram #(.W(MAP_WORD_BITS), .D(MAP_WORDS)) u_free_map (
		.clk(clk), .we(fm_we), .waddr(fm_addr), .wdata(fm_wdata),
		.raddr(fm_addr), .rdata(fm_rdata)
	);
	prau_ram #(.W(PG_W), .D(NUM_PAGES)) u_owner_head (
		.clk(clk), .we(oh_we), .waddr(p_q[PG_W-1:0]), .wdata(base_q),
		.raddr(p_q[PG_W-1:0]), .rdata(oh_rdata)
	);
	prau_ram #(.W(CNT_W), .D(NUM_PAGES)) u_run_length (
		.clk(clk), .we(rl_we), .waddr(base_q), .wdata(want_q),
		.raddr(rl_raddr), .rdata(rl_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (in_valid) begin
				unique case (op_t'(opcode))
					OP_ALLOC:  state_d = (page_count == '0) ? S_DONE : S_A_RD;
					OP_FREE:   state_d = S_F_RD;
					OP_LOOKUP: state_d = S_L_RD;
					OP_NEXT:   state_d = S_N_RD;
				endcase
			end
			S_A_RD:  state_d = (p_q >= bound_q) ? S_DONE : S_A_CHK;
			S_A_CHK: state_d = (pbit && cnt_q + 1'b1 == want_q) ? S_M_RD : S_A_RD;
			S_M_RD:  state_d = S_M_WR;
			S_M_WR:  state_d = (p_inc == run_end) ? S_DONE : S_M_RD;
			S_F_RD:  state_d = S_F_CHK;
			S_F_CHK: state_d = (!pbit && oh_rdata == idx_q && rl_rdata != '0) ? S_F_MRD
				: S_DONE;
			S_F_MRD: state_d = S_F_MWR;
			S_F_MWR: state_d = (p_inc >= (CNT_W+1)'(NUM_PAGES) || cnt_q + 1'b1 == len_q)
				? S_DONE : S_F_MRD;
			S_L_RD:  state_d = (p_q >= bound_q) ? S_DONE : S_L_CHK;
			S_L_CHK: state_d = pbit ? S_DONE : S_L_LEN;
			S_L_LEN: state_d = S_DONE;
			S_N_RD:  state_d = (p_q >= bound_q) ? S_DONE : S_N_CHK;
			S_N_CHK: state_d = (!pbit && oh_rdata == p_q[PG_W-1:0]) ? S_DONE : S_N_RD;
			S_DONE:  state_d = out_free ? S_IDLE : S_DONE;
			default: state_d = S_IDLE;
		endcase
	end

	// memory controls and input stall
	always_comb begin
		in_stall = (state_q != S_IDLE);
		fm_we = (state_q == S_M_WR) || (state_q == S_F_MWR);
		fm_wdata = fm_word;
		fm_wdata[p_q[BIT_W-1:0]] = (state_q == S_F_MWR);
		oh_we = (state_q == S_M_WR);
		rl_we = (state_q == S_M_WR) && (p_q[PG_W-1:0] == base_q);
		rl_raddr = (state_q == S_L_CHK) ? oh_rdata : p_q[PG_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			reserved_q <= '0;
			total_q <= CNT_W'(1024);
			out_valid_q <= 1'b0;
			fm_vld_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_RESERVED) reserved_q <= cfg_data;
				else if (cfg_index == CFG_TOTAL) total_q <= cfg_data;
			end
			if (fm_we) fm_vld_q[fm_addr] <= 1'b1;
			if (state_q == S_DONE && out_free) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		fm_hit_q <= fm_vld_q[fm_addr];
		if (state_q == S_DONE && out_free) begin
			status <= res_st_q;
			head_page <= res_head_q;
			run_pages <= res_len_q;
		end
		unique case (state_q)
			S_IDLE: begin
				want_q <= page_count;
				idx_q <= page_index;
				bound_q <= (total_q < CNT_W'(NUM_PAGES)) ? total_q : CNT_W'(NUM_PAGES);
				p_q <= (op_t'(opcode) == OP_ALLOC) ? reserved_q : {1'b0, page_index};
				cnt_q <= '0;
				res_st_q <= (op_t'(opcode) == OP_NEXT) ? ST_NOTFOUND : ST_BAD;
				res_head_q <= '0;
				res_len_q <= '0;
			end
			S_A_RD: if (p_q >= bound_q) res_st_q <= ST_NOSPACE;
			S_A_CHK: begin
				if (!pbit) begin
					cnt_q <= '0;
					p_q <= p_inc[CNT_W-1:0];
				end else if (cnt_q + 1'b1 == want_q) begin
					if (cnt_q == '0) base_q <= p_q[PG_W-1:0];
					else p_q <= {1'b0, base_q};
				end else begin
					if (cnt_q == '0) base_q <= p_q[PG_W-1:0];
					cnt_q <= cnt_q + 1'b1;
					p_q <= p_inc[CNT_W-1:0];
				end
			end
			S_M_WR: begin
				p_q <= p_inc[CNT_W-1:0];
				res_st_q <= ST_OK;
				res_head_q <= base_q;
				res_len_q <= want_q;
			end
			S_F_CHK: if (!pbit && oh_rdata == idx_q) begin
				len_q <= rl_rdata;
				res_st_q <= ST_OK;
				res_head_q <= idx_q;
				res_len_q <= rl_rdata;
			end
			S_F_MWR: begin
				p_q <= p_inc[CNT_W-1:0];
				cnt_q <= cnt_q + 1'b1;
			end
			S_L_RD: res_st_q <= ST_NOTFOUND;
			S_L_CHK: if (!pbit) res_head_q <= oh_rdata;
			S_L_LEN: begin
				res_st_q <= ST_OK;
				res_len_q <= rl_rdata;
			end
			S_N_CHK: begin
				if (!pbit && oh_rdata == p_q[PG_W-1:0]) begin
					res_st_q <= ST_OK;
					res_head_q <= p_q[PG_W-1:0];
					res_len_q <= rl_rdata;
				end else begin
					p_q <= p_inc[CNT_W-1:0];
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;

	`PRAU_ASSERT(a_stall_busy, clk, arst_n, (state_q == S_IDLE) == !in_stall)
	`PRAU_ASSERT_NEXT(a_post, clk, arst_n, state_q == S_DONE && out_free, out_valid)
	`PRAU_ASSERT(a_cnt, clk, arst_n, !(state_q == S_A_CHK) || cnt_q < want_q)
	`PRAU_ASSERT(a_claim, clk, arst_n, !(state_q == S_M_WR) || (fm_hit_q ? pbit : 1'b1))
endmodule
`default_nettype wire
